>>> rtl/core/lofi_grit_crusher_defines.svh
// Assertion macros shared by the lo-fi grit crusher RTL.
`ifndef LOFI_GRIT_CRUSHER_DEFINES_SVH
`define LOFI_GRIT_CRUSHER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on i_clk, off during reset.
`define LGC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lofi_grit_crusher: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define LGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lofi_grit_crusher: next-cycle check failed");

`else

`define LGC_ASSERT_SAME(lbl, ante, cons)
`define LGC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/lgc_pkg.sv
// Constants and the tanh table for the lo-fi grit crusher.
package lgc_pkg;

    localparam int unsigned ONE_Q15      = 32768;
    localparam int unsigned BYPASS_LIMIT = 327;
    localparam int unsigned ROUND_Q15    = 16384;
    // ceil(2^23 / 10): exact divide-by-ten for operands below 2^22
    localparam logic [19:0] RECIP_TEN    = 20'd838861;
    localparam int unsigned RECIP_SHIFT  = 23;
    localparam int unsigned TANH_SHIFT   = 18;
    localparam int unsigned TANH_ENTRIES = 21;
    // first y at which the curve is held flat (index 20 onward)
    localparam int unsigned TANH_LIMIT   = 20 * (1 << TANH_SHIFT);

    typedef logic [19:0] t_tanh_val;
    typedef t_tanh_val t_tanh_tab [TANH_ENTRIES];

    // tanh over 0..5 in steps of 0.25, Q.20
    localparam t_tanh_tab TANH_TAB = '{
        20'd0,       20'd256816,  20'd484565,  20'd666002,  20'd798589,
        20'd889490,  20'd949117,  20'd987104,  20'd1010856, 20'd1025535,
        20'd1034540, 20'd1040040, 20'd1043391, 20'd1045428, 20'd1046665,
        20'd1047417, 20'd1047873, 20'd1048149, 20'd1048317, 20'd1048420,
        20'd1048481
    };

endpackage

>>> rtl/core/lofi_grit_crusher.sv
// Lo-fi grit crusher: sample-hold, drive, tanh, bit crush and dry/wet blend per stereo frame.
//
// Takes one stereo Q3.20 frame per beat and returns one processed frame. With grit at or
// below 327 (about 0.01) the frame passes straight through and the hold state is left
// alone: the accept goes to ST_FIN, which moves the frame into the output register.
// Otherwise the frame runs through ST_DRV, ST_DRVW, the channel states for left and
// then right, and ST_FIN. One signed multiplier, max(SAMPLE_BITS+1, 22) by 21 bits,
// is shared by a sequencer. It first forms drive = 1 + 2.2g in ST_DRV and ST_DRVW. It
// then runs each channel through drive scaling, tanh interpolation, the dry product
// and the wet product in ST_MAG through ST_SUM. The input is not ready while a frame
// is being worked. A finished frame sits in an output register, so the sequencer
// stalls only when the previous result has not been taken.
// grit_amount is at byte address 0 of the APB port; values above 32768 act as 32768.
`include "lofi_grit_crusher_defines.svh"

module lofi_grit_crusher #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input frames
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_right,
    // output frames
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right
);
    import lgc_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int MA = (SB + 1 > 22) ? SB + 1 : 22;
    localparam int MB = 21;
    localparam int PW = MA + MB;
    localparam int YW = PW - 15;

    localparam logic signed [PW-1:0] OUT_MAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [PW-1:0] OUT_MIN = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRV,
        ST_DRVW,
        ST_MAG,
        ST_TAB,
        ST_INT,
        ST_QNT,
        ST_DRY,
        ST_WET,
        ST_SUM,
        ST_FIN
    } t_state;

    t_state                 r_state;
    logic [15:0]            r_grit;
    logic signed [SB-1:0]   r_held_l, r_held_r;
    logic [2:0]             r_cnt;
    logic signed [SB-1:0]   r_dry_l, r_dry_r;
    logic signed [SB-1:0]   r_res_l, r_res_r;
    logic signed [SB-1:0]   r_out_l, r_out_r;
    logic                   r_out_valid;
    logic [15:0]            r_g;
    logic [19:0]            r_x;
    logic [4:0]             r_shift;
    logic [16:0]            r_drive;
    logic                   r_ch;
    logic                   r_neg;
    logic [19:0]            r_lo;
    logic [17:0]            r_diff;
    logic [17:0]            r_frac;
    logic signed [21:0]     r_q;
    logic signed [PW-1:0]   r_prod;
    logic signed [PW-1:0]   r_acc;

    // config write and readback
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_grit};

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;

    // per-frame setup values derived from grit
    logic [15:0] g_c;
    logic        bypass;
    logic [17:0] hold_acc;
    logic [2:0]  hold_n;
    logic [18:0] bits_acc;
    logic [3:0]  bits_raw;
    logic [3:0]  bits_c;
    logic [4:0]  shift_c;
    logic [19:0] x_c;

    always_comb begin
        g_c      = (r_grit > 16'(ONE_Q15)) ? 16'(ONE_Q15) : r_grit;
        bypass   = (g_c <= 16'(BYPASS_LIMIT));
        hold_acc = 18'(g_c) * 18'd3 + 18'(ROUND_Q15);
        hold_n   = 3'd1 + hold_acc[17:15];
        bits_acc = 19'd360448 - 19'(g_c) * 19'd6;
        bits_raw = bits_acc[18:15];
        bits_c   = (bits_raw < 4'd4) ? 4'd4 : bits_raw;
        shift_c  = 5'd20 - 5'(bits_c);
        x_c      = 20'(g_c) * 20'd22 + 20'd5;
    end

    // channel select
    logic signed [SB-1:0] held_sel;
    logic signed [SB-1:0] dry_sel;
    logic [SB-1:0]        mag;
    assign held_sel = r_ch ? r_held_r : r_held_l;
    assign dry_sel  = r_ch ? r_dry_r : r_dry_l;
    assign mag      = held_sel[SB-1] ? SB'(-held_sel) : SB'(held_sel);

    // shared multiplier
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_DRV: begin
                mul_a = MA'(RECIP_TEN);
                mul_b = MB'(r_x);
            end
            ST_MAG: begin
                mul_a = MA'(mag);
                mul_b = MB'(r_drive);
            end
            ST_INT: begin
                mul_a = MA'(r_frac);
                mul_b = MB'(r_diff);
            end
            ST_DRY: begin
                mul_a = MA'(dry_sel);
                mul_b = MB'(17'(ONE_Q15) - 17'(r_g));
            end
            ST_WET: begin
                mul_a = MA'(r_q);
                mul_b = MB'(r_g);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // tanh lookup from the scaled magnitude
    logic [PW-1:0] y_full;
    logic [YW-1:0] y;
    logic          y_sat;
    logic [4:0]    idx;
    t_tanh_val     tab_lo, tab_hi;

    always_comb begin
        y_full = r_prod + PW'(ROUND_Q15);
        y      = y_full[PW-1:15];
        y_sat  = (y >= YW'(TANH_LIMIT));
        idx    = y_sat ? 5'd19 : y[22:18];
        tab_lo = TANH_TAB[idx];
        tab_hi = TANH_TAB[5'(idx + 5'd1)];
    end

    // interpolation finish, sign and rounding to 2^bits steps
    logic [20:0]        t_mag;
    logic signed [21:0] t_s;
    logic [21:0]        q_half;
    logic [21:0]        q_mask;
    logic [21:0]        q_c;

    always_comb begin
        t_mag  = 21'(r_lo) + 21'(r_prod[35:18]);
        t_s    = r_neg ? -22'(t_mag) : 22'(t_mag);
        q_half = 22'd1 << (r_shift - 5'd1);
        q_mask = ~((22'd1 << r_shift) - 22'd1);
        q_c    = (t_s + q_half) & q_mask;
    end

    // blend sum, rounding shift and saturation
    logic signed [PW-1:0] sum_w;
    logic signed [PW-1:0] sum_sh;
    logic signed [SB-1:0] res_c;

    always_comb begin
        sum_w  = r_acc + r_prod + PW'(ROUND_Q15);
        sum_sh = sum_w >>> 15;
        priority if (sum_sh > OUT_MAX) begin
            res_c = SB'(OUT_MAX);
        end else if (sum_sh < OUT_MIN) begin
            res_c = SB'(OUT_MIN);
        end else begin
            res_c = SB'(sum_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_grit      <= '0;
            r_held_l    <= '0;
            r_held_r    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_ch        <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_grit <= pwdata[15:0];
            end
            // in ST_FIN a taken beat is replaced by the new one below
            if (r_out_valid && i_out_ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_dry_l <= i_sample_left;
                        r_dry_r <= i_sample_right;
                        if (bypass) begin
                            r_res_l <= i_sample_left;
                            r_res_r <= i_sample_right;
                            r_state <= ST_FIN;
                        end else begin
                            if (r_cnt == 3'd0) begin
                                r_held_l <= i_sample_left;
                                r_held_r <= i_sample_right;
                                r_cnt    <= hold_n - 3'd1;
                            end else begin
                                r_cnt <= r_cnt - 3'd1;
                            end
                            r_g     <= g_c;
                            r_x     <= x_c;
                            r_shift <= shift_c;
                            r_ch    <= 1'b0;
                            r_state <= ST_DRV;
                        end
                    end
                end
                ST_DRV: begin
                    r_prod  <= mul_p;
                    r_state <= ST_DRVW;
                end
                ST_DRVW: begin
                    r_drive <= 17'(ONE_Q15) + r_prod[RECIP_SHIFT+16:RECIP_SHIFT];
                    r_state <= ST_MAG;
                end
                ST_MAG: begin
                    r_prod  <= mul_p;
                    r_neg   <= held_sel[SB-1];
                    r_state <= ST_TAB;
                end
                ST_TAB: begin
                    r_lo    <= y_sat ? TANH_TAB[TANH_ENTRIES-1] : tab_lo;
                    r_diff  <= y_sat ? 18'd0 : 18'(tab_hi - tab_lo);
                    r_frac  <= y_sat ? 18'd0 : y[TANH_SHIFT-1:0];
                    r_state <= ST_INT;
                end
                ST_INT: begin
                    r_prod  <= mul_p;
                    r_state <= ST_QNT;
                end
                ST_QNT: begin
                    r_q     <= q_c;
                    r_state <= ST_DRY;
                end
                ST_DRY: begin
                    r_prod  <= mul_p;
                    r_state <= ST_WET;
                end
                ST_WET: begin
                    r_acc   <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    if (!r_ch) begin
                        r_res_l <= res_c;
                        r_ch    <= 1'b1;
                        r_state <= ST_MAG;
                    end else begin
                        r_res_r <= res_c;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // wait for the output register to free up
                    if (!r_out_valid || i_out_ready) begin
                        r_out_l     <= r_res_l;
                        r_out_r     <= r_res_r;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // hold length is at most four frames, so the countdown never passes three
    `LGC_ASSERT_SAME(a_cnt_range, 1'b1, r_cnt <= 3'd3)
    // crush step stays between 10 and 15 bits of shift for any clamped grit, inside the checked 10..16
    `LGC_ASSERT_SAME(a_shift_range, r_state == ST_QNT, r_shift >= 5'd10 && r_shift <= 5'd16)
    // an accepted beat closes the input until the frame is done
    `LGC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // a result is only loaded into a free or draining output register
    `LGC_ASSERT_NEXT(a_no_overwrite, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_left))

endmodule

>>> tb/tb_lofi_grit_crusher.sv
// Self-checking testbench for the lo-fi grit crusher: directed table, then random phases.
`timescale 1ns / 100ps

module tb_lofi_grit_crusher;

    localparam int SAMPLE_BITS     = 24;
    localparam int REG_GRIT_AMOUNT = 0;
    localparam logic [2:0] GRIT_ADDR = 3'(4 * REG_GRIT_AMOUNT);
    localparam int GRIT_ONE        = 32768;
    localparam int BYPASS_LIMIT    = 327;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int PHASES          = 10;
    localparam int PHASE_FRAMES    = 75;
    localparam int MAX_REPORTS     = 40;

    localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } t_frame;

    typedef struct packed {
        logic [15:0]        grit;
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               fixed;
        logic signed [23:0] want_l;
        logic signed [23:0] want_r;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic signed [23:0]     i_sample_left;
    logic signed [23:0]     i_sample_right;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [23:0]     o_out_left;
    logic signed [23:0]     o_out_right;

    lofi_grit_crusher #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right)
    );

    always #6 i_clk = ~i_clk;

    // mirror of the block's register and hold state
    logic [15:0]        grit_reg;
    logic signed [23:0] held_l;
    logic signed [23:0] held_r;
    logic [2:0]         hold_left;
    bit                 grit_set;

    t_frame    crushed_frames[$];
    t_stim_row grit_table[$];
    t_frame    head;

    bit calm;
    int out_stall;
    int cycles;
    int frames_in;
    int frames_out;
    int bad_fields;
    int grit_writes;
    int directed_rows;

    function automatic longint tanh_point(int idx);
        case (idx)
            0:  return 0;
            1:  return 256816;
            2:  return 484565;
            3:  return 666002;
            4:  return 798589;
            5:  return 889490;
            6:  return 949117;
            7:  return 987104;
            8:  return 1010856;
            9:  return 1025535;
            10: return 1034540;
            11: return 1040040;
            12: return 1043391;
            13: return 1045428;
            14: return 1046665;
            15: return 1047417;
            16: return 1047873;
            17: return 1048149;
            18: return 1048317;
            19: return 1048420;
            default: return 1048481;
        endcase
    endfunction

    // drive, tanh shaping, crush to 2^bits steps, then wet/dry blend with saturation
    function automatic logic signed [23:0] crush_channel(longint held, longint dry, longint g,
                                                         int bits, longint drive);
        longint mag, y, idx, frac, t, u, q, r;
        int     s;
        mag  = (held < 0) ? -held : held;
        y    = (mag * drive + 16384) >>> 15;
        idx  = y >>> 18;
        frac = y & ((longint'(1) << 18) - 1);
        if (idx >= 20) begin
            t = tanh_point(20);
        end else begin
            t = tanh_point(int'(idx)) + (((tanh_point(int'(idx) + 1) - tanh_point(int'(idx)))
                * frac) >>> 18);
        end
        if (held < 0)
            t = -t;
        s = 20 - bits;
        // offset keeps the rounding mask working on a nonnegative value
        u = t + (longint'(1) << 21) + (longint'(1) << (s - 1));
        u = u & ~((longint'(1) << s) - 1);
        q = u - (longint'(1) << 21);
        r = (dry * (GRIT_ONE - g) + q * g + 16384) >>> 15;
        if (r > longint'(S_MAX))
            r = longint'(S_MAX);
        if (r < longint'(S_MIN))
            r = longint'(S_MIN);
        return r[23:0];
    endfunction

    function automatic void crush_frame(input logic signed [23:0] dl, input logic signed [23:0] dr,
                                        output logic signed [23:0] ol,
                                        output logic signed [23:0] orr);
        longint g, drive;
        int     bits, hold_n;
        g = (grit_reg > 16'd32768) ? GRIT_ONE : longint'(grit_reg);
        if (g <= BYPASS_LIMIT) begin
            ol  = dl;
            orr = dr;
            return;
        end
        bits = int'((11 * GRIT_ONE - 6 * g) >>> 15);
        if (bits < 4)
            bits = 4;
        hold_n = int'(1 + ((3 * g + 16384) >>> 15));
        drive  = GRIT_ONE + (22 * g + 5) / 10;
        if (hold_left == 3'd0) begin
            held_l    = dl;
            held_r    = dr;
            hold_left = hold_n[2:0];
        end
        hold_left = hold_left - 3'd1;
        ol  = crush_channel(held_l, dl, g, bits, drive);
        orr = crush_channel(held_r, dr, g, bits, drive);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [23:0] rand_sample();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return 24'sd0;
                    default: return -24'sd1;
                endcase
            end
            1, 2, 3, 4: return 24'($urandom);
            default: begin
                // +-2.0 keeps most driven values inside the interpolated part of the curve
                v = int'($urandom_range(0, 4194303)) - 2097152;
                return v[23:0];
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic signed [23:0] want,
                                   logic signed [23:0] got);
        bad_fields++;
        if (bad_fields <= MAX_REPORTS)
            $display("%0t ns: %s want %0d got %0d", $time, what, want, got);
    endtask

    task automatic add_row(logic [15:0] grit, logic signed [23:0] l, logic signed [23:0] r);
        grit_table.push_back({grit, l, r, 1'b0, 24'sd0, 24'sd0});
    endtask

    task automatic add_fixed(logic [15:0] grit, logic signed [23:0] l, logic signed [23:0] r,
                             logic signed [23:0] wl, logic signed [23:0] wr);
        grit_table.push_back({grit, l, r, 1'b1, wl, wr});
    endtask

    task automatic write_grit(logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GRIT_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        grit_reg = value;
        grit_set = 1'b1;
        grit_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (crushed_frames.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_frame(t_stim_row row);
        int                 gap;
        logic signed [23:0] pl, pr;
        t_frame             f;
        if (!grit_set || row.grit != grit_reg) begin
            i_in_valid <= 1'b0;
            wait_idle();
            write_grit(row.grit);
        end
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_left  <= row.left;
        i_sample_right <= row.right;
        do @(posedge i_clk); while (!o_in_ready);
        crush_frame(row.left, row.right, pl, pr);
        if (row.fixed) begin
            f.left  = row.want_l;
            f.right = row.want_r;
        end else begin
            f.left  = pl;
            f.right = pr;
        end
        crushed_frames.push_back(f);
        frames_in++;
    endtask

    // result side: random stalls, no new ones started while calm
    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            out_stall   <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                out_stall <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (crushed_frames.size() == 0) begin
                report_mismatch("beat with nothing pending, left", 24'sd0, o_out_left);
            end else begin
                head = crushed_frames.pop_front();
                if (o_out_left !== head.left)
                    report_mismatch("out_left", head.left, o_out_left);
                if (o_out_right !== head.right)
                    report_mismatch("out_right", head.right, o_out_right);
                frames_out++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames pending", cycles,
                     crushed_frames.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int         p, i;
        logic [15:0] g;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_in_valid     <= 1'b0;
        i_sample_left  <= '0;
        i_sample_right <= '0;
        i_out_ready    <= 1'b0;
        out_stall      = 0;
        calm           = 1'b0;
        cycles         = 0;
        frames_in      = 0;
        frames_out     = 0;
        bad_fields     = 0;
        grit_writes    = 0;
        grit_set       = 1'b0;
        grit_reg       = 16'd0;
        held_l         = '0;
        held_r         = '0;
        hold_left      = 3'd0;

        // bypass: output equals input, hold state untouched
        add_fixed(16'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        add_fixed(16'd0, S_MAX, S_MIN, S_MAX, S_MIN);
        add_fixed(16'd0, S_MIN, S_MAX, S_MIN, S_MAX);
        add_fixed(16'd0, -24'sd1, 24'sd1, -24'sd1, 24'sd1);
        add_fixed(16'd327, 24'sh123456, -24'sh654321, 24'sh123456, -24'sh654321);
        add_fixed(16'd327, S_MAX, S_MIN, S_MAX, S_MIN);
        // full grit, first capture of a silent frame stays silent
        add_fixed(16'd32768, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        add_row(16'd32768, S_MAX, S_MIN);
        // grit drops mid-hold: the old countdown runs out first
        add_row(16'd328, S_MIN, S_MAX);
        add_row(16'd328, 24'sd5, -24'sd5);
        add_row(16'd328, 24'sh100000, -24'sh040000);
        add_row(16'd328, S_MAX, S_MIN);
        // grit above one acts as one
        add_row(16'hFFFF, S_MAX, S_MIN);
        add_row(16'hFFFF, -24'sd1, 24'sd1);
        add_row(16'hFFFF, 24'sh3FFFFF, -24'sh400000);
        add_row(16'hFFFF, 24'sd0, 24'sd0);
        add_row(16'd16384, 24'sh080000, -24'sh080000);
        add_row(16'd16384, S_MAX, 24'sd1);
        add_row(16'd16384, -24'sh7FFFFF, -24'sd2);
        add_fixed(16'd0, 24'sh2AAAAA, -24'sh155556, 24'sh2AAAAA, -24'sh155556);
        add_row(16'd20000, 24'sh0C0000, 24'sh1FFFFF);
        add_row(16'd20000, -24'sh0C0000, 24'sh000001);
        add_row(16'd20000, 24'sh040000, -24'sh1FFFFF);
        directed_rows = grit_table.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (grit_table[k])
            run_frame(grit_table[k]);

        for (p = 0; p < PHASES; p++) begin
            case (p)
                1:       g = 16'd0;
                2:       g = 16'd32768;
                4:       g = 16'd328;
                5:       g = 16'hFFFF;
                7:       g = 16'd327;
                8:       g = 16'($urandom_range(0, 65535));
                default: g = 16'($urandom_range(BYPASS_LIMIT + 1, GRIT_ONE));
            endcase
            calm = (p % 3 == 2);
            for (i = 0; i < PHASE_FRAMES; i++)
                run_frame({g, rand_sample(), rand_sample(), 1'b0, 24'sd0, 24'sd0});
        end

        i_in_valid <= 1'b0;
        calm = 1'b0;
        wait_idle();

        $display("%0d frames sent (%0d from the directed table), %0d checked, %0d grit writes",
                 frames_in, directed_rows, frames_out, grit_writes);
        $display("%0d field mismatches in %0d cycles", bad_fields, cycles);
        if (bad_fields == 0 && crushed_frames.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lgc_pkg.sv
rtl/core/lofi_grit_crusher.sv
tb/tb_lofi_grit_crusher.sv
